// ===== rtl/fmenc_pkg.sv =====
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the frame encoder.
package fmenc_pkg;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LONG  = 2'd1;
  localparam logic [1:0] ST_NOT_OPEN  = 2'd2;
  localparam logic [1:0] ST_WAS_OPEN  = 2'd3;

  localparam logic [1:0] OP_HDR = 2'd0;
  localparam logic [1:0] OP_PAY = 2'd1;
  localparam logic [1:0] OP_ERR = 2'd2;

  localparam logic       CMD_HEADER  = 1'b0;
  localparam logic       CMD_PAYLOAD = 1'b1;

  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_VERSION     = 2'd2;
  localparam logic [1:0] REG_CAPACITY    = 2'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [16:0] FRAME_OVERHEAD = 17'd10;
  localparam logic [16:0] CAPACITY_RESET = 17'd65545;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic        command;
    logic [7:0]  message_type;
    logic [15:0] sequence_req;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       frame_end;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  status;
    logic        last;
    logic [7:0]  message_type;
    logic [15:0] sequence_req;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] protocol_version;
  } frame_cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/fmenc_front.sv =====
// Front end: accepts items, tracks the open frame and classifies each item into a command.
module fmenc_front #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fmenc_pkg::in_item_t in_data,
  input  logic [16:0]        capacity,
  input  logic               q_full,
  output logic               q_push,
  output fmenc_pkg::cmd_t    q_cmd
);
  import fmenc_pkg::*;

  logic        open_r, open_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic        too_long;
  logic [15:0] remain_dec;

  assign in_stall   = q_full;
  assign q_push     = in_valid && !q_full;
  assign remain_dec = remain_r - 16'd1;
  assign too_long   = ({1'b0, in_data.payload_length} > 17'(MAX_PAYLOAD)) ||
                      (({1'b0, in_data.payload_length} + FRAME_OVERHEAD) > capacity);

  always_comb begin
    open_nxt             = open_r;
    remain_nxt           = remain_r;
    q_cmd.op             = OP_ERR;
    q_cmd.status         = ST_OK;
    q_cmd.last           = 1'b0;
    q_cmd.message_type   = in_data.message_type;
    q_cmd.sequence_req   = in_data.sequence_req;
    q_cmd.payload_length = in_data.payload_length;
    q_cmd.data_byte      = in_data.data_byte;
    if (in_data.command == CMD_HEADER) begin
      if (open_r) begin
        q_cmd.status = ST_WAS_OPEN;
      end else if (too_long) begin
        q_cmd.status = ST_TOO_LONG;
      end else begin
        q_cmd.op   = OP_HDR;
        q_cmd.last = (in_data.payload_length == 16'd0);
        open_nxt   = (in_data.payload_length != 16'd0);
        remain_nxt = in_data.payload_length;
      end
    end else begin
      if (!open_r) begin
        q_cmd.status = ST_NOT_OPEN;
      end else begin
        q_cmd.op   = OP_PAY;
        q_cmd.last = (remain_dec == 16'd0);
        open_nxt   = (remain_dec != 16'd0);
        remain_nxt = remain_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      remain_r <= 16'd0;
    end else if (q_push) begin
      open_r   <= open_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

// ===== rtl/fmenc_queue.sv =====
// Short command queue between the front end and the byte serializer.
module fmenc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fmenc_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output fmenc_pkg::cmd_t head_cmd
);
  import fmenc_pkg::*;

  cmd_t                mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/fmenc_back.sv =====
// Back end: expands queued commands into frame bytes, runs the CRC, drives the output register.
module fmenc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fmenc_pkg::frame_cfg_t cfg,
  input  logic                  q_valid,
  input  fmenc_pkg::cmd_t       q_cmd,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output fmenc_pkg::out_item_t  out_data
);
  import fmenc_pkg::*;

  localparam logic [3:0] STEP_SYNC1  = 4'd0;
  localparam logic [3:0] STEP_SYNC2  = 4'd1;
  localparam logic [3:0] STEP_VER    = 4'd2;
  localparam logic [3:0] STEP_TYPE   = 4'd3;
  localparam logic [3:0] STEP_SEQ_LO = 4'd4;
  localparam logic [3:0] STEP_SEQ_HI = 4'd5;
  localparam logic [3:0] STEP_LEN_LO = 4'd6;
  localparam logic [3:0] STEP_LEN_HI = 4'd7;
  localparam logic [3:0] STEP_CRC_LO = 4'd8;
  localparam logic [3:0] STEP_CRC_HI = 4'd9;
  localparam logic [3:0] PSTEP_DATA   = 4'd0;
  localparam logic [3:0] PSTEP_CRC_LO = 4'd1;
  localparam logic [3:0] PSTEP_CRC_HI = 4'd2;

  logic [3:0]  step_r, step_nxt;
  logic [15:0] crc_r, crc_nxt, crc_in;
  logic        out_valid_r;
  out_item_t   out_data_r, item;
  logic        advance, fire, done;

  assign advance   = !out_valid_r || !out_stall;
  assign fire      = q_valid && advance;
  assign q_pop     = fire && done;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign crc_in    = (step_r == STEP_VER) ? CRC_INIT : crc_r;

  always_comb begin
    item             = '0;
    item.byte_valid  = 1'b1;
    item.status      = ST_OK;
    crc_nxt          = crc_r;
    done             = 1'b0;
    unique case (q_cmd.op)
      OP_HDR: begin
        case (step_r)
          STEP_SYNC1:  item.out_byte = cfg.sync_first;
          STEP_SYNC2:  item.out_byte = cfg.sync_second;
          STEP_VER:    item.out_byte = cfg.protocol_version;
          STEP_TYPE:   item.out_byte = q_cmd.message_type;
          STEP_SEQ_LO: item.out_byte = q_cmd.sequence_req[7:0];
          STEP_SEQ_HI: item.out_byte = q_cmd.sequence_req[15:8];
          STEP_LEN_LO: item.out_byte = q_cmd.payload_length[7:0];
          STEP_LEN_HI: item.out_byte = q_cmd.payload_length[15:8];
          STEP_CRC_LO: item.out_byte = crc_r[7:0];
          default:     item.out_byte = crc_r[15:8];
        endcase
        if (step_r inside {[STEP_VER:STEP_LEN_HI]}) begin
          crc_nxt = crc_byte(crc_in, item.out_byte);
        end
        done            = q_cmd.last ? (step_r == STEP_CRC_HI) : (step_r == STEP_LEN_HI);
        item.frame_end  = (step_r == STEP_CRC_HI);
        if (item.frame_end) crc_nxt = CRC_INIT;
      end
      OP_PAY: begin
        case (step_r)
          PSTEP_DATA: begin
            item.out_byte = q_cmd.data_byte;
            crc_nxt       = crc_byte(crc_r, q_cmd.data_byte);
          end
          PSTEP_CRC_LO: item.out_byte = crc_r[7:0];
          default:      item.out_byte = crc_r[15:8];
        endcase
        done           = q_cmd.last ? (step_r == PSTEP_CRC_HI) : (step_r == PSTEP_DATA);
        item.frame_end = (step_r == PSTEP_CRC_HI);
        if (item.frame_end) crc_nxt = CRC_INIT;
      end
      default: begin
        item.byte_valid = 1'b0;
        item.status     = q_cmd.status;
        done            = 1'b1;
      end
    endcase
    item.last_of_run = done;
    step_nxt         = done ? 4'd0 : 4'(step_r + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= 4'd0;
      crc_r       <= CRC_INIT;
    end else begin
      if (advance) out_valid_r <= q_valid;
      if (fire) begin
        step_r <= step_nxt;
        crc_r  <= crc_nxt;
      end
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.frame_end |-> out_data_r.last_of_run && out_data_r.byte_valid)
    else $error("frame end byte not marked last or not valid");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.byte_valid |-> out_data_r.last_of_run &&
      out_data_r.status != ST_OK)
    else $error("error result malformed");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.frame_end |=> crc_r == CRC_INIT && step_r == 4'd0)
    else $error("crc not restarted after frame end");

endmodule

// ===== rtl/framed_message_encoder_crc16.sv =====
// Top level of the framed message encoder with CRC-16/CCITT-FALSE trailer.
// Each input item yields one or more output bytes, one per clock unless stalled: a header
// gives 8 bytes (10 with the CRC when its payload is empty), a payload byte gives 1 (3 on
// the last byte of the frame), a rejected item gives one error result. The output
// serializer sets the rate, one result per cycle unless stalled, so payload items flow at
// one per cycle and headers hold the output while their bytes go out; a 4-entry command
// queue between the classifier and the serializer lets input keep arriving meanwhile. An
// accepted item passes the queue memory, then the output register. Configuration
// registers sit at byte addresses 0, 4, 8, 12 and must only be written while idle.
module framed_message_encoder_crc16 #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  fmenc_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output fmenc_pkg::out_item_t  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import fmenc_pkg::*;

  logic [7:0]  sync_first_r, sync_second_r, version_r;
  logic [16:0] capacity_r;
  logic        cfg_wr;
  logic [1:0]  cfg_sel;
  frame_cfg_t  cfg;
  logic        q_full, q_push, q_pop, q_valid;
  cmd_t        push_cmd, head_cmd;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_sel)
      REG_SYNC_FIRST:  prdata = {24'd0, sync_first_r};
      REG_SYNC_SECOND: prdata = {24'd0, sync_second_r};
      REG_VERSION:     prdata = {24'd0, version_r};
      default:         prdata = {15'd0, capacity_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= 8'd0;
      sync_second_r <= 8'd0;
      version_r     <= 8'd0;
      capacity_r    <= CAPACITY_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_SYNC_FIRST:  sync_first_r  <= pwdata[7:0];
        REG_SYNC_SECOND: sync_second_r <= pwdata[7:0];
        REG_VERSION:     version_r     <= pwdata[7:0];
        default:         capacity_r    <= pwdata[16:0];
      endcase
    end
  end

  assign cfg.sync_first       = sync_first_r;
  assign cfg.sync_second      = sync_second_r;
  assign cfg.protocol_version = version_r;

  fmenc_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .capacity (capacity_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  fmenc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  fmenc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== sim/framed_message_encoder_crc16_tb.sv =====
// Self-checking testbench for the framed message encoder: random traffic, predicted byte stream.
`timescale 1ns / 100ps

import fmenc_pkg::*;

class frame_scoreboard;
  out_item_t   expected_q[$];
  int          errors;
  int unsigned payload_limit;
  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [7:0]  version;
  logic [16:0] capacity;
  logic [15:0] crc;
  logic [15:0] remaining;
  bit          frame_open;

  function new(int unsigned limit);
    payload_limit = limit;
    errors        = 0;
    sync_first    = 8'h00;
    sync_second   = 8'h00;
    version       = 8'h00;
    capacity      = CAPACITY_RESET;
    crc           = CRC_INIT;
    remaining     = 16'h0000;
    frame_open    = 1'b0;
  endfunction

  static function logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_SYNC_FIRST: begin
        sync_first = val[7:0];
      end
      REG_SYNC_SECOND: begin
        sync_second = val[7:0];
      end
      REG_VERSION: begin
        version = val[7:0];
      end
      default: begin
        capacity = val[16:0];
      end
    endcase
  endfunction

  function void push(logic [7:0] b, logic v, logic fe, logic [1:0] st);
    out_item_t r;
    r.out_byte    = b;
    r.byte_valid  = v;
    r.last_of_run = 1'b0;
    r.frame_end   = fe;
    r.status      = st;
    expected_q.push_back(r);
  endfunction

  function void close_frame();
    push(crc[7:0], 1'b1, 1'b0, ST_OK);
    push(crc[15:8], 1'b1, 1'b1, ST_OK);
    crc        = CRC_INIT;
    remaining  = 16'h0000;
    frame_open = 1'b0;
  endfunction

  function void note_input(in_item_t it);
    logic [7:0] hdr [0:5];
    out_item_t  tail;
    if (it.command == CMD_HEADER) begin
      if (frame_open) begin
        push(8'h00, 1'b0, 1'b0, ST_WAS_OPEN);
      end else if (it.payload_length > payload_limit ||
                   ({1'b0, it.payload_length} + FRAME_OVERHEAD) > capacity) begin
        push(8'h00, 1'b0, 1'b0, ST_TOO_LONG);
      end else begin
        hdr[0] = version;
        hdr[1] = it.message_type;
        hdr[2] = it.sequence_req[7:0];
        hdr[3] = it.sequence_req[15:8];
        hdr[4] = it.payload_length[7:0];
        hdr[5] = it.payload_length[15:8];
        push(sync_first, 1'b1, 1'b0, ST_OK);
        push(sync_second, 1'b1, 1'b0, ST_OK);
        crc = CRC_INIT;
        for (int i = 0; i < 6; i++) begin
          crc = crc16_update(crc, hdr[i]);
          push(hdr[i], 1'b1, 1'b0, ST_OK);
        end
        if (it.payload_length == 16'h0000) begin
          close_frame();
        end else begin
          frame_open = 1'b1;
          remaining  = it.payload_length;
        end
      end
    end else begin
      if (!frame_open) begin
        push(8'h00, 1'b0, 1'b0, ST_NOT_OPEN);
      end else begin
        crc = crc16_update(crc, it.data_byte);
        push(it.data_byte, 1'b1, 1'b0, ST_OK);
        remaining = remaining - 16'd1;
        if (remaining == 16'h0000) begin
          close_frame();
        end
      end
    end
    tail = expected_q.pop_back();
    tail.last_of_run = 1'b1;
    expected_q.push_back(tail);
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected item, expected none, actual byte %h valid %b last %b end %b st %0d",
               $time, got.out_byte, got.byte_valid, got.last_of_run, got.frame_end, got.status);
      return;
    end
    want = expected_q.pop_front();
    compare_field("out_byte", want.out_byte, got.out_byte);
    compare_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, got.byte_valid});
    compare_field("last_of_run", {7'd0, want.last_of_run}, {7'd0, got.last_of_run});
    compare_field("frame_end", {7'd0, want.frame_end}, {7'd0, got.frame_end});
    compare_field("status", {6'd0, want.status}, {6'd0, got.status});
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module framed_message_encoder_crc16_tb;

  localparam int PAYLOAD_LIMIT = 256;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frame_scoreboard sb;
  int cycles;
  int burst_left;
  int items_sent;
  int stall_mode;
  int stall_left;

  framed_message_encoder_crc16 #(
    .MAX_PAYLOAD(PAYLOAD_LIMIT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: runs of no stall, random stall and solid stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = (stall_mode == 2) ? $urandom_range(1, 6) : $urandom_range(1, 40);
    end
    stall_left--;
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 9) < 3);
      end
      default: begin
        out_stall <= 1'b1;
      end
    endcase
  end

  function automatic in_item_t hdr_item(logic [7:0] mtype, logic [15:0] seq, logic [15:0] len);
    in_item_t it;
    it.command        = CMD_HEADER;
    it.message_type   = mtype;
    it.sequence_req   = seq;
    it.payload_length = len;
    it.data_byte      = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t pay_item(logic [7:0] b);
    in_item_t it;
    it.command        = CMD_PAYLOAD;
    it.message_type   = 8'($urandom_range(0, 255));
    it.sequence_req   = 16'($urandom_range(0, 65535));
    it.payload_length = 16'($urandom_range(0, 65535));
    it.data_byte      = b;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 5);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_frame(input int len);
    send_item(hdr_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 16'(len)));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(hdr_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535))));
      end
      send_item(pay_item(8'($urandom_range(0, 255))));
    end
  endtask

  task automatic drain_out();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] s1, input logic [7:0] s2,
                            input logic [7:0] ver, input logic [16:0] cap);
    reg_write(REG_SYNC_FIRST, {24'd0, s1});
    reg_write(REG_SYNC_SECOND, {24'd0, s2});
    reg_write(REG_VERSION, {24'd0, ver});
    reg_write(REG_CAPACITY, {15'd0, cap});
  endtask

  initial begin
    int ph;
    int pick;
    int len;
    int phase_end;
    logic [16:0] cap;
    sb         = new(PAYLOAD_LIMIT);
    cycles     = 0;
    burst_left = 0;
    items_sent = 0;
    stall_mode = 0;
    stall_left = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = 4'h0;
    pwdata     = 32'h0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: error paths, empty frame, field extremes, capacity edges
    set_config(8'hFF, 8'h00, 8'hA5, CAPACITY_RESET);
    send_item(pay_item(8'h3C));
    send_item(hdr_item(8'hFF, 16'hFFFF, 16'd0));
    send_item(hdr_item(8'h00, 16'h0000, 16'd0));
    send_item(hdr_item(8'h12, 16'h1234, 16'd257));
    send_item(hdr_item(8'h34, 16'h8001, 16'hFFFF));
    send_item(hdr_item(8'h56, 16'h00FF, 16'd3));
    send_item(hdr_item(8'h78, 16'hFF00, 16'd2));
    send_item(pay_item(8'h00));
    send_item(pay_item(8'hFF));
    send_item(pay_item(8'hA5));
    send_item(hdr_item(8'h9A, 16'h5555, 16'd1));
    send_item(pay_item(8'h80));
    drain_out();
    set_config(8'h00, 8'hFF, 8'h00, 17'd10);
    send_item(hdr_item(8'h01, 16'h0001, 16'd0));
    send_item(hdr_item(8'h02, 16'h0002, 16'd1));
    drain_out();
    set_config(8'h55, 8'hAA, 8'hFF, 17'd9);
    send_item(hdr_item(8'h03, 16'h0003, 16'd0));
    drain_out();
    reg_write(REG_CAPACITY, 32'd265);
    send_item(hdr_item(8'h04, 16'h0004, 16'd256));
    drain_out();

    // random phases, one setting each
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: cap = CAPACITY_RESET;
        1: cap = 17'($urandom_range(10, 40));
        2: cap = 17'd0;
        3: cap = 17'($urandom_range(0, 65545));
        4: cap = 17'd266;
        default: cap = 17'd10;
      endcase
      set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), cap);
      if (ph == 0) begin
        send_frame(PAYLOAD_LIMIT);
      end
      phase_end = items_sent + 5;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
          send_frame(len);
        end else if (pick == 7) begin
          send_item(pay_item(8'($urandom_range(0, 255))));
        end else begin
          len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535) : $urandom_range(250, 270);
          send_item(hdr_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                             16'(len)));
        end
        while (sb.frame_open) begin
          send_item(pay_item(8'($urandom_range(0, 255))));
        end
      end
      drain_out();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
